FILE: rtl/aabb_pkg.sv
// Shared types and constants for the local-to-world box bounds block.
package aabb_pkg;

   localparam int SCALE_WIDTH = 16;   // Q8.8
   localparam int SCALE_FRAC  = 8;
   localparam int QUAT_WIDTH  = 16;   // Q1.14
   localparam int QUAT_FRAC   = 14;
   localparam int MAT_WIDTH   = 22;   // rounded matrix entry, Q.14
   localparam int RMAT_WIDTH  = 36;   // unrounded matrix entry, Q.28
   localparam int AXES        = 3;
   localparam int CORNER_COUNT = 8;   // box corners, one lo/hi choice per axis
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 6;

   localparam logic [CSR_DATA_WIDTH-1:0] QUAT_RESET = 64'h4000_0000_0000_0000;
   localparam logic signed [SCALE_WIDTH-1:0] SCALE_RESET = 16'sd256;

   typedef enum logic [2:0] {
      CSR_OFFSET_X = 3'd0,
      CSR_OFFSET_Y = 3'd1,
      CSR_OFFSET_Z = 3'd2,
      CSR_SCALE_X  = 3'd3,
      CSR_SCALE_Y  = 3'd4,
      CSR_SCALE_Z  = 3'd5,
      CSR_ROTATION = 3'd6
   } csr_index_type;

endpackage

FILE: rtl/aabb_local_to_world_bounds.sv
// Four-stage pipeline: 8 box corners scaled, rotated, offset and reduced to world bounds.
// rsp_valid comes from the stage 4 register; one box per cycle sustained unless rsp_ready stalls.
// The eight corners are handled at once: each axis product is formed for the min and max
// input only (24 multipliers), and bounds come from per-term min and max sums.
// Rotation matrix is rebuilt in a register in the cycle after the quaternion is written.
// Synchronous active-high reset empties the pipeline and loads identity transform registers.
module aabb_local_to_world_bounds
   import aabb_pkg::*;
#(
   parameter int COORD_WIDTH  = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [COORD_WIDTH-1:0]   req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0]   req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0]   req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0]   req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0]   req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0]   req_box_max_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [COORD_WIDTH-1:0]   rsp_world_min_x,
   output logic signed [COORD_WIDTH-1:0]   rsp_world_min_y,
   output logic signed [COORD_WIDTH-1:0]   rsp_world_min_z,
   output logic signed [COORD_WIDTH-1:0]   rsp_world_max_x,
   output logic signed [COORD_WIDTH-1:0]   rsp_world_max_y,
   output logic signed [COORD_WIDTH-1:0]   rsp_world_max_z,
   output logic                            rsp_saturated,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]       paddr,
   input  logic [CSR_DATA_WIDTH-1:0]       pwdata,
   output logic [CSR_DATA_WIDTH-1:0]       prdata,
   output logic                            pready
);

   localparam int W    = COORD_WIDTH;
   localparam int SP_W = W + SCALE_WIDTH;        // coord * scale
   localparam int S_W  = W + SCALE_WIDTH - SCALE_FRAC + 1;
   localparam int P_W  = MAT_WIDTH + S_W;
   localparam int A_W  = P_W + 2;
   localparam int R_W  = A_W - QUAT_FRAC + 1;
   localparam int O_W  = R_W + 1;

   // ---------------- configuration ----------------
   logic signed [W-1:0]           offset_ff [AXES];
   logic signed [SCALE_WIDTH-1:0] scale_ff  [AXES];
   logic [CSR_DATA_WIDTH-1:0]     quat_ff;
   logic signed [MAT_WIDTH-1:0]   m_ff [AXES][AXES];
   logic                          csr_write;
   csr_index_type                 csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            offset_ff[a] <= '0;
            scale_ff[a]  <= SCALE_RESET;
         end
         quat_ff <= QUAT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OFFSET_X: offset_ff[0] <= pwdata[W-1:0];
            CSR_OFFSET_Y: offset_ff[1] <= pwdata[W-1:0];
            CSR_OFFSET_Z: offset_ff[2] <= pwdata[W-1:0];
            CSR_SCALE_X:  scale_ff[0]  <= pwdata[SCALE_WIDTH-1:0];
            CSR_SCALE_Y:  scale_ff[1]  <= pwdata[SCALE_WIDTH-1:0];
            CSR_SCALE_Z:  scale_ff[2]  <= pwdata[SCALE_WIDTH-1:0];
            CSR_ROTATION: quat_ff      <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_OFFSET_X: prdata = CSR_DATA_WIDTH'($unsigned(offset_ff[0]));
         CSR_OFFSET_Y: prdata = CSR_DATA_WIDTH'($unsigned(offset_ff[1]));
         CSR_OFFSET_Z: prdata = CSR_DATA_WIDTH'($unsigned(offset_ff[2]));
         CSR_SCALE_X:  prdata = CSR_DATA_WIDTH'($unsigned(scale_ff[0]));
         CSR_SCALE_Y:  prdata = CSR_DATA_WIDTH'($unsigned(scale_ff[1]));
         CSR_SCALE_Z:  prdata = CSR_DATA_WIDTH'($unsigned(scale_ff[2]));
         CSR_ROTATION: prdata = quat_ff;
         default:      prdata = '0;
      endcase
   end

   // rotation matrix from the quaternion, Q.28 then rounded to Q.14
   logic signed [QUAT_WIDTH-1:0]   qw, qx, qy, qz;
   logic signed [RMAT_WIDTH-1:0]   xx, yy, zz, xy, xz, yz, wx, wy, wz;
   logic signed [RMAT_WIDTH-1:0]   one_q28;
   logic signed [RMAT_WIDTH-1:0]   r_mat [AXES][AXES];
   logic signed [MAT_WIDTH-1:0]    m_in  [AXES][AXES];

   assign qw = quat_ff[63:48];
   assign qx = quat_ff[47:32];
   assign qy = quat_ff[31:16];
   assign qz = quat_ff[15:0];
   assign one_q28 = RMAT_WIDTH'(1) <<< (2*QUAT_FRAC);

   always_comb begin
      xx = RMAT_WIDTH'(qx) * RMAT_WIDTH'(qx);
      yy = RMAT_WIDTH'(qy) * RMAT_WIDTH'(qy);
      zz = RMAT_WIDTH'(qz) * RMAT_WIDTH'(qz);
      xy = RMAT_WIDTH'(qx) * RMAT_WIDTH'(qy);
      xz = RMAT_WIDTH'(qx) * RMAT_WIDTH'(qz);
      yz = RMAT_WIDTH'(qy) * RMAT_WIDTH'(qz);
      wx = RMAT_WIDTH'(qw) * RMAT_WIDTH'(qx);
      wy = RMAT_WIDTH'(qw) * RMAT_WIDTH'(qy);
      wz = RMAT_WIDTH'(qw) * RMAT_WIDTH'(qz);
      r_mat[0][0] = one_q28 - ((yy + zz) <<< 1);
      r_mat[0][1] = (xy - wz) <<< 1;
      r_mat[0][2] = (xz + wy) <<< 1;
      r_mat[1][0] = (xy + wz) <<< 1;
      r_mat[1][1] = one_q28 - ((xx + zz) <<< 1);
      r_mat[1][2] = (yz - wx) <<< 1;
      r_mat[2][0] = (xz - wy) <<< 1;
      r_mat[2][1] = (yz + wx) <<< 1;
      r_mat[2][2] = one_q28 - ((xx + yy) <<< 1);
      for (int i = 0; i < AXES; i++) begin
         for (int j = 0; j < AXES; j++) begin
            m_in[i][j] = MAT_WIDTH'((r_mat[i][j] + (RMAT_WIDTH'(1) <<< (QUAT_FRAC-1)))
                                    >>> QUAT_FRAC);
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
   end

   // ---------------- pipeline handshake ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ready1, ready2, ready3, ready4;

   assign ready4    = !v4_ff || rsp_ready;
   assign ready3    = !v3_ff || ready4;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_ready = ready1;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: per-axis scaling of min and max ----------------
   logic signed [W-1:0]    lo_in [AXES];
   logic signed [W-1:0]    hi_in [AXES];
   logic signed [S_W-1:0]  slo_in [AXES];
   logic signed [S_W-1:0]  shi_in [AXES];
   logic signed [S_W-1:0]  slo_ff [AXES];
   logic signed [S_W-1:0]  shi_ff [AXES];
   logic signed [SP_W:0]   sp_lo, sp_hi;

   always_comb begin
      lo_in[0] = req_box_min_x;
      lo_in[1] = req_box_min_y;
      lo_in[2] = req_box_min_z;
      hi_in[0] = req_box_max_x;
      hi_in[1] = req_box_max_y;
      hi_in[2] = req_box_max_z;
      sp_lo = '0;
      sp_hi = '0;
      for (int j = 0; j < AXES; j++) begin
         sp_lo = (SP_W+1)'(lo_in[j]) * (SP_W+1)'(scale_ff[j]);
         sp_hi = (SP_W+1)'(hi_in[j]) * (SP_W+1)'(scale_ff[j]);
         slo_in[j] = S_W'((sp_lo + ((SP_W+1)'(1) <<< (SCALE_FRAC-1))) >>> SCALE_FRAC);
         shi_in[j] = S_W'((sp_hi + ((SP_W+1)'(1) <<< (SCALE_FRAC-1))) >>> SCALE_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && ready1) begin
         slo_ff <= slo_in;
         shi_ff <= shi_in;
      end
   end

   // ---------------- stage 2: matrix products for both choices ----------------
   logic signed [P_W-1:0] plo_ff [AXES][AXES];
   logic signed [P_W-1:0] phi_ff [AXES][AXES];

   always_ff @(posedge clock) begin
      if (v1_ff && ready2) begin
         for (int i = 0; i < AXES; i++) begin
            for (int j = 0; j < AXES; j++) begin
               plo_ff[i][j] <= P_W'(m_ff[i][j]) * P_W'(slo_ff[j]);
               phi_ff[i][j] <= P_W'(m_ff[i][j]) * P_W'(shi_ff[j]);
            end
         end
      end
   end

   // ---------------- stage 3: extreme sums over the corners ----------------
   // each corner picks lo or hi per term independently, so the extremes are
   // the sums of the per-term extremes
   logic signed [A_W-1:0] amin_in [AXES];
   logic signed [A_W-1:0] amax_in [AXES];
   logic signed [A_W-1:0] amin_ff [AXES];
   logic signed [A_W-1:0] amax_ff [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         amin_in[i] = '0;
         amax_in[i] = '0;
         for (int j = 0; j < AXES; j++) begin
            if (plo_ff[i][j] < phi_ff[i][j]) begin
               amin_in[i] = amin_in[i] + A_W'(plo_ff[i][j]);
               amax_in[i] = amax_in[i] + A_W'(phi_ff[i][j]);
            end else begin
               amin_in[i] = amin_in[i] + A_W'(phi_ff[i][j]);
               amax_in[i] = amax_in[i] + A_W'(plo_ff[i][j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff && ready3) begin
         amin_ff <= amin_in;
         amax_ff <= amax_in;
      end
   end

   // ---------------- stage 4: round, offset, clip ----------------
   localparam logic signed [O_W-1:0] CLIP_LO = -(O_W'(1) <<< (W-1));
   localparam logic signed [O_W-1:0] CLIP_HI = (O_W'(1) <<< (W-1)) - O_W'(1);

   logic signed [A_W:0]   rnd_min, rnd_max;
   logic signed [O_W-1:0] pmin, pmax;
   logic signed [W-1:0]   wmin_in [AXES];
   logic signed [W-1:0]   wmax_in [AXES];
   logic signed [W-1:0]   wmin_ff [AXES];
   logic signed [W-1:0]   wmax_ff [AXES];
   logic                  sat_in, sat_ff;

   always_comb begin
      sat_in  = 1'b0;
      rnd_min = '0;
      rnd_max = '0;
      pmin    = '0;
      pmax    = '0;
      for (int i = 0; i < AXES; i++) begin
         rnd_min = ((A_W+1)'(amin_ff[i]) + ((A_W+1)'(1) <<< (QUAT_FRAC-1))) >>> QUAT_FRAC;
         rnd_max = ((A_W+1)'(amax_ff[i]) + ((A_W+1)'(1) <<< (QUAT_FRAC-1))) >>> QUAT_FRAC;
         pmin = O_W'($signed(rnd_min[R_W-1:0])) + O_W'(offset_ff[i]);
         pmax = O_W'($signed(rnd_max[R_W-1:0])) + O_W'(offset_ff[i]);
         if (pmin < CLIP_LO) begin
            wmin_in[i] = CLIP_LO[W-1:0];
            sat_in = 1'b1;
         end else if (pmin > CLIP_HI) begin
            wmin_in[i] = CLIP_HI[W-1:0];
         end else begin
            wmin_in[i] = pmin[W-1:0];
         end
         if (pmax > CLIP_HI) begin
            wmax_in[i] = CLIP_HI[W-1:0];
            sat_in = 1'b1;
         end else if (pmax < CLIP_LO) begin
            wmax_in[i] = CLIP_LO[W-1:0];
         end else begin
            wmax_in[i] = pmax[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff && ready4) begin
         wmin_ff <= wmin_in;
         wmax_ff <= wmax_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_world_min_x = wmin_ff[0];
   assign rsp_world_min_y = wmin_ff[1];
   assign rsp_world_min_z = wmin_ff[2];
   assign rsp_world_max_x = wmax_ff[0];
   assign rsp_world_max_y = wmax_ff[1];
   assign rsp_world_max_z = wmax_ff[2];
   assign rsp_saturated   = sat_ff;

`ifndef SYNTHESIS
   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (wmin_ff[0] <= wmax_ff[0]) && (wmin_ff[1] <= wmax_ff[1])
                    && (wmin_ff[2] <= wmax_ff[2]))
      else $error("world min above world max");
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !v1_ff && !v2_ff && !v3_ff && !v4_ff)
      else $error("pipeline not empty after reset");
   a_stall_holds_stage3: assert property (@(posedge clock) disable iff (reset)
      v3_ff && v4_ff && !rsp_ready |=> v3_ff)
      else $error("stage 3 transaction lost during stall");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_ready)
      else $error("input blocked with empty first stage");
`endif

endmodule
